@@ rtl/b64enc_pkg.sv @@
// Shared types, constants and the sextet-to-character map for the base64 encoder.
package b64enc_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       message_end;
  } out_word_t;

  // one closed group: 24 bits, bytes held minus one (0..2), final flag
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  extra;
    logic        fin;
  } group_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      sextet_char = 8'(w + 8'h41);
    end else if (v < 6'd52) begin
      sextet_char = 8'(w + 8'h47);
    end else if (v < 6'd62) begin
      sextet_char = 8'(w - 8'h04);
    end else if (v == 6'd62) begin
      sextet_char = 8'h2B;
    end else begin
      sextet_char = 8'h2F;
    end
  endfunction

endpackage

@@ rtl/base64_stream_encoder_core.sv @@
// Top level of the streaming base64 encoder.
// Streaming base64 encoder, standard alphabet with '=' padding. Push one byte
// word per cycle with final_byte set on the last byte of each message; empty
// messages are not supported. Every third byte, or any byte flagged final,
// closes a group that yields exactly four character words: the data characters
// followed by '=' padding, run_last set on the fourth and message_end set on the
// fourth of a final group. Bytes are taken one per cycle while the group queue
// (GROUP_DEPTH entries) has room; the back end drains one character per cycle
// while the consumer keeps popping, so each group occupies the serializer for
// four characters and the sustained input rate is set by that serializer. With
// an idle queue the first character of a group passes through the group queue
// and the output register before it reaches the result ports.
module base64_stream_encoder_core #(
  parameter int GROUP_DEPTH = 2  // closed groups buffered between front and back, >= 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  b64enc_pkg::in_word_t  byte_word,
  output logic                  empty,
  input  logic                  pop,
  output b64enc_pkg::out_word_t char_word
);

  b64enc_pkg::group_t grp_in;
  b64enc_pkg::group_t grp_head;
  logic               grp_push;
  logic               grp_pop;
  logic               grp_full;
  logic               grp_empty;

  // byte intake and grouping
  b64enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .byte_word (byte_word),
    .q_full    (grp_full),
    .full      (full),
    .q_push    (grp_push),
    .q_data    (grp_in)
  );

  // decouples intake from character output
  b64enc_fifo #(
    .DEPTH (GROUP_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (grp_push),
    .wr_data  (grp_in),
    .rd_en    (grp_pop),
    .rd_data  (grp_head),
    .is_full  (grp_full),
    .is_empty (grp_empty)
  );

  // one character per cycle from the head group while the consumer pops
  b64enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (grp_head),
    .q_empty   (grp_empty),
    .q_pop     (grp_pop),
    .pop       (pop),
    .empty     (empty),
    .char_word (char_word)
  );

endmodule

@@ rtl/b64enc_front.sv @@
// Front end: accepts bytes, holds up to two pending, closes groups into the queue.
module b64enc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64enc_pkg::in_word_t byte_word,
  input  logic                q_full,
  output logic                full,
  output logic                q_push,
  output b64enc_pkg::group_t  q_data
);

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic [7:0] pend0;
  logic [7:0] pend1;
  logic       accept;
  logic       hold;
  logic [1:0] cnt_eff;

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign cnt_eff = cnt[1] ? 2'd2 : cnt;  // unreachable count of three acts as two
  assign hold    = !byte_word.final_byte && (cnt_eff != 2'd2);
  assign q_push  = accept && !hold;

  always_comb begin
    q_data.extra = cnt_eff;
    q_data.fin   = byte_word.final_byte;
    case (cnt_eff)
      2'd0:    q_data.bits = {byte_word.data_byte, 16'h0000};
      2'd1:    q_data.bits = {pend0, byte_word.data_byte, 8'h00};
      default: q_data.bits = {pend0, pend1, byte_word.data_byte};
    endcase
    cnt_next = cnt;
    if (accept) begin
      cnt_next = hold ? 2'(cnt_eff + 2'd1) : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold) begin
      if (cnt_eff == 2'd0) begin
        pend0 <= byte_word.data_byte;
      end else begin
        pend1 <= byte_word.data_byte;
      end
    end
  end

endmodule

@@ rtl/b64enc_fifo.sv @@
// Short queue of closed groups between front and back.
module b64enc_fifo #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  b64enc_pkg::group_t wr_data,
  input  logic               rd_en,
  output b64enc_pkg::group_t rd_data,
  output logic               is_full,
  output logic               is_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  b64enc_pkg::group_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign do_wr    = wr_en && !is_full;
  assign do_rd    = rd_en && !is_empty;
  assign rd_data  = mem[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= bump(wr_ptr);
      if (do_rd) rd_ptr <= bump(rd_ptr);
      if (do_wr && !do_rd) begin
        count <= CW'(count + 1'b1);
      end else if (do_rd && !do_wr) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ rtl/b64enc_back.sv @@
// Back end: serializes each group into four characters through an output register.
module b64enc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  b64enc_pkg::group_t    q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output b64enc_pkg::out_word_t char_word
);

  logic [1:0] idx;
  logic       ovalid;
  logic       load;
  logic [5:0] sextet;
  logic [7:0] ch;
  logic       is_data;

  assign empty = !ovalid;
  assign load  = !q_empty && (!ovalid || pop);
  assign q_pop = load && (idx == 2'd3);

  always_comb begin
    case (idx)
      2'd0:    sextet = q_head.bits[23:18];
      2'd1:    sextet = q_head.bits[17:12];
      2'd2:    sextet = q_head.bits[11:6];
      default: sextet = q_head.bits[5:0];
    endcase
    // data characters: bytes held plus one
    is_data = ({1'b0, idx} <= 3'({1'b0, q_head.extra} + 3'd1));
    ch      = is_data ? b64enc_pkg::sextet_char(sextet) : b64enc_pkg::PAD_CHAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= 2'd0;
      ovalid <= 1'b0;
    end else begin
      if (load) begin
        idx    <= 2'(idx + 2'd1);
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_word.out_char    <= ch;
      char_word.run_last    <= (idx == 2'd3);
      char_word.message_end <= (idx == 2'd3) && q_head.fin;
    end
  end

endmodule
